>>> src/pip_pkg.sv
// Shared constants and types for the point-in-polygon core.
package pip_pkg;

  localparam int MaxVertices = 256;
  localparam int CoordWidth  = 24;
  localparam int AddrWidth   = $clog2(MaxVertices);
  localparam int CountWidth  = $clog2(MaxVertices + 1);
  localparam int DiffWidth   = CoordWidth + 2;
  localparam int ProdWidth   = 2 * DiffWidth;
  localparam int DistWidth   = 2 * DiffWidth + 1;
  localparam int EdgeWidth   = 8;

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    logic clear_cnt;
    logic append;
    logic load_point;
    logic rd_en;
    logic [AddrWidth-1:0] rd_addr;
    logic cross_first;
    logic cross_step;
    logic near_first;
    logic near_step;
  } pip_cmd_t;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic parity;
  } pip_sts_t;

endpackage

>>> src/point_in_polygon_nearest_segment_core.sv
// Top level of the point-in-polygon core with nearest-edge report.
//
//  channel | ports                                   | dir
//  in      | in_valid/in_ready, kind, coord_x/y      | beat in
//  out     | out_valid/out_ready, inside, edge, ovf  | beat out
//  cfg     | cfg_valid/cfg_ready, cfg_invert_inside  | beat in
//
// Clear, append and a query of an empty polygon finish in the idle state; any
// other query runs a crossing pass and, when the point is inside, a nearest
// pass, one vertex a cycle through the vertex memories' single read port.
// Reset empties the polygon and clears invert_inside.
// A result waits in the output register; a query finishes only once it is free.
module point_in_polygon_nearest_segment_core
  import pip_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  input  coord_t               in_coord_x,
  input  coord_t               in_coord_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_inside_res,
  output logic [EdgeWidth-1:0] out_nearest_edge,
  output logic                 out_overflow,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_invert_inside
);

  pip_cmd_t cmd;
  pip_sts_t sts;
  logic [EdgeWidth-1:0] best_edge;
  logic invert_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      invert_r <= 1'b0;
    end else if (cfg_valid) begin
      invert_r <= cfg_invert_inside;
    end
  end

  pip_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_kind,
    .out_valid, .out_ready, .out_inside_res, .out_nearest_edge, .out_overflow,
    .cmd, .sts, .best_edge
  );

  pip_datapath u_dp (
    .clk, .rst_n, .cmd, .invert_inside(invert_r),
    .in_x(in_coord_x), .in_y(in_coord_y), .sts, .best_edge
  );

endmodule

>>> src/pip_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/pip_datapath.sv
// Vertex store, crossing test and nearest-midpoint search.
module pip_datapath
  import pip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  pip_cmd_t              cmd,
  input  logic                  invert_inside,
  input  coord_t                in_x,
  input  coord_t                in_y,
  output pip_sts_t              sts,
  output logic [EdgeWidth-1:0]  best_edge
);

  logic [CountWidth-1:0] count_r, count_nxt;
  coord_t px_r, py_r;
  coord_t rx, ry;
  coord_t xp_r, yp_r;
  logic inside_r, inside_nxt;
  logic [AddrWidth-1:0] idx_r, idx_nxt;
  logic [DistWidth-1:0] best_d_r;
  logic [AddrWidth-1:0] best_i_r;

  logic signed [DiffWidth-1:0] a, b, c, d, dx, dy;
  logic signed [ProdWidth-1:0] p1, p2;
  logic [ProdWidth-1:0] sx, sy;
  logic [DistWidth-1:0] dist_sum;
  coord_t xi, yi, xj, yj;
  logic flip, cross_cond;

  pip_ram #(.Width(CoordWidth), .Depth(MaxVertices)) u_ram_x (
    .clk, .we(cmd.append), .waddr(count_r[AddrWidth-1:0]), .wdata(in_x),
    .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rx)
  );
  pip_ram #(.Width(CoordWidth), .Depth(MaxVertices)) u_ram_y (
    .clk, .we(cmd.append), .waddr(count_r[AddrWidth-1:0]), .wdata(in_y),
    .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(ry)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear_cnt) begin
      count_nxt = '0;
    end else if (cmd.append) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // edge from previous vertex (xj) to current (xi)
  always_comb begin
    xi = rx;
    yi = ry;
    xj = xp_r;
    yj = yp_r;
    a = DiffWidth'(yj) - DiffWidth'(yi);
    b = DiffWidth'(px_r) - DiffWidth'(xi);
    c = DiffWidth'(xj) - DiffWidth'(xi);
    d = DiffWidth'(py_r) - DiffWidth'(yi);
    p1 = a * b;
    p2 = c * d;
    cross_cond = ((yi < yj) && (yi < py_r) && (py_r <= yj) && (p1 > p2)) ||
                 ((yi > yj) && (yi > py_r) && (py_r >= yj) && (p1 < p2));
    flip = cmd.cross_step && cross_cond;
    inside_nxt = inside_r;
    if (cmd.load_point) begin
      inside_nxt = invert_inside;
    end else if (flip) begin
      inside_nxt = ~inside_r;
    end
    dx = DiffWidth'(xp_r) + DiffWidth'(rx) - (DiffWidth'(px_r) <<< 1);
    dy = DiffWidth'(yp_r) + DiffWidth'(ry) - (DiffWidth'(py_r) <<< 1);
    sx = dx * dx;
    sy = dy * dy;
    dist_sum = DistWidth'(sx) + DistWidth'(sy);
    idx_nxt = idx_r;
    if (cmd.cross_first || cmd.near_first) begin
      idx_nxt = '0;
    end else if (cmd.near_step) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      inside_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      inside_r <= inside_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (cmd.load_point) begin
      px_r <= in_x;
      py_r <= in_y;
    end
    if (cmd.cross_first || cmd.near_first || cmd.cross_step || cmd.near_step) begin
      xp_r <= rx;
      yp_r <= ry;
    end
    if (cmd.near_step && (idx_r == '0 || dist_sum < best_d_r)) begin
      best_d_r <= dist_sum;
      best_i_r <= idx_r;
    end
  end

  assign sts.count  = count_r;
  assign sts.parity = inside_r;
  assign best_edge  = EdgeWidth'(best_i_r);

endmodule

>>> src/pip_ctrl.sv
// Controller sequencing clears, appends and the two passes of a query.
module pip_ctrl
  import pip_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_kind,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_inside_res,
  output logic [EdgeWidth-1:0] out_nearest_edge,
  output logic                 out_overflow,
  output pip_cmd_t             cmd,
  input  pip_sts_t             sts,
  input  logic [EdgeWidth-1:0] best_edge
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLAST = 3'd1;
  localparam logic [2:0] ST_CROSS = 3'd2;
  localparam logic [2:0] ST_NLAST = 3'd3;
  localparam logic [2:0] ST_NEAR  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [CountWidth-1:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic ins_r, ins_nxt, ovf_r, ovf_nxt;
  logic [EdgeWidth-1:0] edge_r, edge_nxt;
  logic accept, out_free;
  logic [CountWidth-1:0] n;

  assign n        = sts.count;
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // cross pass: prime with vertex n-1, then steps over vertices 0..n-1
  // near pass: prime with vertex 0, steps over 1..n-1 then vertex 0 again
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ins_nxt = ins_r;
    ovf_nxt = ovf_r;
    edge_nxt = edge_r;
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_CLEAR: cmd.clear_cnt = 1'b1;
            KIND_APPEND: begin
              out_valid_nxt = 1'b1;
              ins_nxt = 1'b0;
              edge_nxt = '0;
              ovf_nxt = (n >= CountWidth'(MaxVertices));
              cmd.append = !ovf_nxt;
            end
            KIND_QUERY: begin
              cmd.load_point = 1'b1;
              if (n == '0) begin
                out_valid_nxt = 1'b1;
                ins_nxt = 1'b0;
                edge_nxt = '0;
                ovf_nxt = 1'b0;
              end else begin
                cmd.rd_en = 1'b1;
                cmd.rd_addr = AddrWidth'(n - 1'b1);
                state_nxt = ST_CLAST;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CLAST: begin
        cmd.cross_first = 1'b1;
        cmd.rd_en = 1'b1;
        cmd.rd_addr = '0;
        cnt_nxt = CountWidth'(1);
        state_nxt = ST_CROSS;
      end
      ST_CROSS: begin
        cmd.cross_step = 1'b1;
        if (cnt_r == n) begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = '0;
          state_nxt = ST_NLAST;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = AddrWidth'(cnt_r);
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_NLAST: begin
        if (!sts.parity) begin
          ins_nxt = 1'b0;
          edge_nxt = '0;
          ovf_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          cmd.near_first = 1'b1;
          cmd.rd_en = 1'b1;
          cmd.rd_addr = (n == CountWidth'(1)) ? '0 : AddrWidth'(1);
          cnt_nxt = CountWidth'(2);
          state_nxt = ST_NEAR;
        end
      end
      ST_NEAR: begin
        cmd.near_step = 1'b1;
        if (cnt_r > n) begin
          ins_nxt = 1'b1;
          ovf_nxt = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = (cnt_r == n) ? '0 : AddrWidth'(cnt_r);
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (ins_r) begin
          edge_nxt = best_edge;
        end
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    ins_r  <= ins_nxt;
    ovf_r  <= ovf_nxt;
    edge_r <= edge_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_inside_res   = ins_r;
  assign out_nearest_edge = edge_r;
  assign out_overflow     = ovf_r;

endmodule

>>> src/pip_checker.sv
// Port-level checks for the point-in-polygon core.
module pip_checker
  import pip_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_inside_res,
  input logic [EdgeWidth-1:0] out_nearest_edge,
  input logic                 out_overflow
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_nearest_edge))
    else $error("out beat changed while stalled");

  a_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> !out_inside_res && out_nearest_edge == '0)
    else $error("overflow beat carries query data");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_inside_res |-> out_nearest_edge == '0)
    else $error("edge reported for outside point");

  a_accept_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("in beat taken while out beat stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("beat after reset");

endmodule

bind point_in_polygon_nearest_segment_core pip_checker u_pip_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_inside_res, .out_nearest_edge, .out_overflow
);

>>> tb/tb_top.sv
// Self-checking testbench of the point-in-polygon core with nearest-edge report.
module tb_top;
  import pip_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic                 inside_res;
    logic [EdgeWidth-1:0] nearest_edge;
    logic                 overflow;
  } pip_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_kind;
  coord_t               in_coord_x;
  coord_t               in_coord_y;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_inside_res;
  logic [EdgeWidth-1:0] out_nearest_edge;
  logic                 out_overflow;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_invert_inside;

  point_in_polygon_nearest_segment_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_inside_res   (out_inside_res),
    .out_nearest_edge (out_nearest_edge),
    .out_overflow     (out_overflow),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_invert_inside(cfg_invert_inside)
  );

  longint   poly_x [MaxVertices];
  longint   poly_y [MaxVertices];
  int       poly_count;
  bit       invert_mode;
  pip_res_t pending_results[$];
  int       error_count;
  int       send_idle_pct;
  int       recv_idle_pct;
  int       recv_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic bit polygon_eval(input logic [1:0] k, input coord_t cx, input coord_t cy,
                                      output pip_res_t r);
    longint px, py, xi, yi, xj, yj, c, dx, dy, d, bestd;
    int     n, j, nx, best;
    bit     ins;
    r = '0;
    px = cx;
    py = cy;
    n = poly_count;
    if (k == KIND_CLEAR) begin
      poly_count = 0;
      return 1'b0;
    end
    if (k == KIND_APPEND) begin
      if (poly_count >= MaxVertices) begin
        r.overflow = 1'b1;
      end else begin
        poly_x[poly_count] = px;
        poly_y[poly_count] = py;
        poly_count++;
      end
      return 1'b1;
    end
    if (k != KIND_QUERY) return 1'b0;
    if (n == 0) return 1'b1;
    ins = invert_mode;
    for (int i = 0; i < n; i++) begin
      j = (i == 0) ? n - 1 : i - 1;
      xi = poly_x[i]; yi = poly_y[i];
      xj = poly_x[j]; yj = poly_y[j];
      c = (yj - yi) * (px - xi) - (xj - xi) * (py - yi);
      if ((yi < yj && yi < py && py <= yj && c > 0) ||
          (yi > yj && yi > py && py >= yj && c < 0))
        ins = ~ins;
    end
    if (!ins) return 1'b1;
    best = 0;
    bestd = 0;
    for (int i = 0; i < n; i++) begin
      nx = (i + 1 == n) ? 0 : i + 1;
      dx = poly_x[i] + poly_x[nx] - 2 * px;
      dy = poly_y[i] + poly_y[nx] - 2 * py;
      d = dx * dx + dy * dy;
      if (i == 0 || d < bestd) begin
        bestd = d;
        best = i;
      end
    end
    r.inside_res = 1'b1;
    r.nearest_edge = best[EdgeWidth-1:0];
    return 1'b1;
  endfunction

  task automatic send_item(input logic [1:0] k, input longint x, input longint y);
    pip_res_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_coord_x <= x[CoordWidth-1:0];
    in_coord_y <= y[CoordWidth-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (polygon_eval(k, x[CoordWidth-1:0], y[CoordWidth-1:0], r))
      pending_results = {pending_results, r};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_invert(input bit v);
    drain_results();
    cfg_valid         <= 1'b1;
    cfg_invert_inside <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    invert_mode = v;
    @(posedge clk);
  endtask

  function automatic longint rand_coord();
    return longint'($signed($urandom_range(24'hFFFFFF, 0) & 32'hFFFFFF) << 8) >>> 8;
  endfunction

  function automatic longint near(input longint c, input longint span);
    return c + longint'($urandom_range(2 * span)) - span;
  endfunction

  task automatic build_shape(input int n, input longint cx, input longint cy,
                             input longint span);
    send_item(KIND_CLEAR, rand_coord(), rand_coord());
    for (int i = 0; i < n; i++) send_item(KIND_APPEND, near(cx, span), near(cy, span));
  endtask

  task automatic test_directed();
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_APPEND, -4096, -4096);
    send_item(KIND_APPEND, 4096, -4096);
    send_item(KIND_APPEND, 4096, 4096);
    send_item(KIND_APPEND, -4096, 4096);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, 3000, 100);
    send_item(KIND_QUERY, 9000, 0);
    send_item(KIND_QUERY, -4096, -4096);
    send_item(KIND_QUERY, 4096, 0);
    send_item(KIND_UNUSED, 0, 0);
    send_item(KIND_CLEAR, 0, 0);
    send_item(KIND_APPEND, -8388608, -8388608);
    send_item(KIND_APPEND, 8388607, -8388608);
    send_item(KIND_APPEND, 8388607, 8388607);
    send_item(KIND_APPEND, -8388608, 8388607);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, 8388607, 8388607);
    send_item(KIND_QUERY, -8388608, 1);
    write_invert(1'b1);
    send_item(KIND_QUERY, 0, 0);
    send_item(KIND_QUERY, 8388607, -8388608);
    send_item(KIND_CLEAR, -1, -1);
    send_item(KIND_QUERY, 0, 0);
    write_invert(1'b0);
  endtask

  task automatic test_overflow();
    build_shape(MaxVertices, 0, 0, 1 << 20);
    send_item(KIND_APPEND, 1, 1);
    send_item(KIND_APPEND, -1, -1);
    for (int i = 0; i < 4; i++) send_item(KIND_QUERY, near(0, 1 << 19), near(0, 1 << 19));
    send_item(KIND_CLEAR, 0, 0);
  endtask

  task automatic test_random(input int items);
    int     sent;
    int     n;
    longint cx, cy, span;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(9))
        0: begin
          send_item(2'($urandom_range(3)), rand_coord(), rand_coord());
          sent++;
        end
        1: begin
          send_item(KIND_CLEAR, rand_coord(), rand_coord());
          send_item(KIND_QUERY, rand_coord(), rand_coord());
          sent += 2;
        end
        default: begin
          n = $urandom_range(3, 9);
          span = longint'(1) << $urandom_range(2, 21);
          cx = near(0, (1 << 22) - span);
          cy = near(0, (1 << 22) - span);
          if ($urandom_range(7) == 0) begin
            span = 1 << 23;
            cx = 0;
            cy = 0;
          end
          build_shape(n, cx, cy, span);
          for (int q = $urandom_range(2, 6); q > 0; q--) begin
            send_item(KIND_QUERY, near(cx, span), near(cy, span));
            sent++;
          end
          sent += n + 1;
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    build_shape(4, 0, 0, 1 << 12);
    recv_hold_cycles = 300;
    for (int i = 0; i < 20; i++) send_item(KIND_QUERY, near(0, 1 << 12), near(0, 1 << 12));
  endtask

  task automatic test_pause();
    drain_results();
    build_shape(5, 1000, -1000, 1 << 15);
    send_item(KIND_QUERY, 1000, -1000);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          pip_res_t w;
          w = pending_results.pop_front();
          if (out_inside_res !== w.inside_res)
            report_mismatch("inside_res", out_inside_res, w.inside_res);
          if (out_nearest_edge !== w.nearest_edge)
            report_mismatch("nearest_edge", out_nearest_edge, w.nearest_edge);
          if (out_overflow !== w.overflow)
            report_mismatch("overflow", out_overflow, w.overflow);
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    error_count       = 0;
    poly_count        = 0;
    invert_mode       = 1'b0;
    recv_hold_cycles  = 0;
    send_idle_pct     = 27;
    recv_idle_pct     = 53;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_kind           <= KIND_CLEAR;
    in_coord_x        <= '0;
    in_coord_y        <= '0;
    out_ready         <= 1'b0;
    cfg_valid         <= 1'b0;
    cfg_invert_inside <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(230);
    test_backpressure();
    write_invert(1'b1);
    send_idle_pct = 53;
    recv_idle_pct = 27;
    test_random(230);
    test_pause();
    write_invert(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(230);
    drain_results();
    repeat (600) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
